// ===== rtl/core/ilst_pkg.sv =====
// Shared constants and codes for the indexed list store.
`default_nettype none
package ilst_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 9;
  localparam int VAL_W    = 32;
  localparam int ST_W     = 2;
  localparam int LEN_W    = 9;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [FUNC_W-1:0] OP_READ     = 3'd0;
  localparam logic [FUNC_W-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [FUNC_W-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [FUNC_W-1:0] OP_INS_POS  = 3'd3;
  localparam logic [FUNC_W-1:0] OP_DELETE   = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/core/indexed_list_store.sv =====
// Top level of the indexed list store: request sequencer, shift engine and entry RAM.
//
//   channel   signals                                  handshake
//   -------   --------------------------------------   ----------------------------
//   request   func, position, item_value               taken when start && !busy
//   result    read_value, status, list_length          one-cycle strobe on done
//
// Entries are kept packed in RAM cells 0 .. length-1 in list order. An insert
// moves the later entries up one cell and a delete moves them down one cell,
// one entry per cycle through the single RAM read port and write port.
// After an item is taken, the sequencer decides in S_DECIDE, where a rejected
// request, an unused code, an append and a delete of the last entry end; a
// read goes on to S_RDATA, an insert moves its entries in S_ISHIFT and then
// writes the new one in S_IWRITE, and a delete moves its entries in S_DSHIFT.
// The result strobe rises in the cycle busy falls, so the next item can be taken
// in that same cycle. Reset clears the length and the sequencer; the RAM is
// not cleared, since no value read from a cell at or above the length is used. The
// receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module indexed_list_store (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic        [ilst_pkg::FUNC_W-1:0] func,
  input  wire logic        [ilst_pkg::POS_W-1:0]  position,
  input  wire logic signed [ilst_pkg::VAL_W-1:0]  item_value,
  output logic                                    done,
  output logic signed      [ilst_pkg::VAL_W-1:0]  read_value,
  output logic             [ilst_pkg::ST_W-1:0]   status,
  output logic             [ilst_pkg::LEN_W-1:0]  list_length
);
  import ilst_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RDATA  = 3'd2;
  localparam logic [2:0] S_ISHIFT = 3'd3;
  localparam logic [2:0] S_IWRITE = 3'd4;
  localparam logic [2:0] S_DSHIFT = 3'd5;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [ADDR_W-1:0] tgt, tgt_next;

  // Request held for the whole operation.
  logic [FUNC_W-1:0] op_func;
  logic [POS_W-1:0]  op_pos;
  logic [VAL_W-1:0]  op_val;

  // RAM port signals.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  // Result of the current cycle, registered onto the ports.
  logic              emit;
  logic [VAL_W-1:0]  res_value;
  logic [ST_W-1:0]   res_status;

  logic              pos_lt, pos_le, full;

  assign busy   = (state != S_IDLE);
  assign pos_lt = CMP_W'(op_pos) <  CMP_W'(count);
  assign pos_le = CMP_W'(op_pos) <= CMP_W'(count);
  assign full   = (count >= CNT_W'(CAPACITY));

  ilst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    tgt_next   = tgt;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = ram_rdata;
    ram_raddr  = idx;
    emit       = 1'b0;
    res_value  = '1;
    res_status = ST_DONE;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        unique case (op_func) inside
          OP_READ: begin
            if (pos_lt) begin
              ram_raddr  = ADDR_W'(op_pos);
              state_next = S_RDATA;
            end else begin
              res_status = ST_RANGE;
              emit       = 1'b1;
              state_next = S_IDLE;
            end
          end

          OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
            if (op_func == OP_INS_POS && !pos_le) begin
              // The range check comes before the full check.
              res_status = ST_RANGE;
              emit       = 1'b1;
              state_next = S_IDLE;
            end else if (full) begin
              res_status = ST_FULL;
              emit       = 1'b1;
              state_next = S_IDLE;
            end else begin
              // Target cell of the new entry; the shift starts at the tail.
              if (op_func == OP_INS_HEAD) begin
                tgt_next = '0;
              end else if (op_func == OP_INS_TAIL) begin
                tgt_next = ADDR_W'(count);
              end else begin
                tgt_next = ADDR_W'(op_pos);
              end
              idx_next = ADDR_W'(count);
              if (tgt_next == ADDR_W'(count)) begin
                // Appending: nothing to move.
                ram_we     = 1'b1;
                ram_waddr  = tgt_next;
                ram_wdata  = op_val;
                count_next = count + CNT_W'(1);
                emit       = 1'b1;
                state_next = S_IDLE;
              end else begin
                ram_raddr  = ADDR_W'(count) - ADDR_W'(1);
                state_next = S_ISHIFT;
              end
            end
          end

          OP_DELETE: begin
            if (!pos_lt) begin
              res_status = ST_RANGE;
              emit       = 1'b1;
              state_next = S_IDLE;
            end else if (CNT_W'(op_pos) + CNT_W'(1) == count) begin
              // Last entry: only the length shrinks.
              count_next = count - CNT_W'(1);
              emit       = 1'b1;
              state_next = S_IDLE;
            end else begin
              idx_next   = ADDR_W'(op_pos);
              ram_raddr  = ADDR_W'(op_pos) + ADDR_W'(1);
              state_next = S_DSHIFT;
            end
          end

          default: begin
            // Unused codes change nothing.
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end

      S_RDATA: begin
        res_value  = ram_rdata;
        emit       = 1'b1;
        state_next = S_IDLE;
      end

      S_ISHIFT: begin
        // Cell idx takes the entry read from cell idx-1 last cycle.
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        idx_next  = idx - ADDR_W'(1);
        ram_raddr = idx - ADDR_W'(2);
        if (idx_next == tgt) begin
          state_next = S_IWRITE;
        end
      end

      S_IWRITE: begin
        ram_we     = 1'b1;
        ram_waddr  = tgt;
        ram_wdata  = op_val;
        count_next = count + CNT_W'(1);
        emit       = 1'b1;
        state_next = S_IDLE;
      end

      S_DSHIFT: begin
        // Cell idx takes the entry read from cell idx+1 last cycle.
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        idx_next  = idx + ADDR_W'(1);
        ram_raddr = idx + ADDR_W'(2);
        if (!(CNT_W'(idx) + CNT_W'(2) < count)) begin
          count_next = count - CNT_W'(1);
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    tgt <= tgt_next;
    if (start && !busy) begin
      op_func <= func;
      op_pos  <= position;
      op_val  <= $unsigned(item_value);
    end
    if (emit) begin
      read_value  <= $signed(res_value);
      status      <= res_status;
      list_length <= LEN_W'(count_next);
    end
  end

  // A result is only shown once the sequencer has returned to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while the sequencer is busy");

  // The length never exceeds the store.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  // The RAM is written only during an operation.
  a_we_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy)
    else $error("RAM write while idle");

  // The reported length matches the held length.
  a_len_match: assert property (@(posedge clk) disable iff (rst)
    done |-> (list_length == LEN_W'(count)))
    else $error("reported length differs from held length");

endmodule
`default_nettype wire

// ===== rtl/core/ilst_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ilst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
